// ----- design/dsa_pkg.sv -----
// Shared types and constants for the descriptor slot allocator.
// Used by dsa_ctrl, dsa_datapath and descriptor_slot_allocator; no dependencies.
package dsa_pkg;

	localparam int INDEX_W  = 10;
	localparam int CNT_W    = 11;
	localparam int ADDR_W   = 48;
	localparam int STRIDE_W = 13;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int REGIDX_W = 2;
	localparam int PROD_W   = INDEX_W + STRIDE_W;

	localparam int MAX_SLOTS_DEF = 1024;

	// request kinds
	localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

	// configuration register indexes
	localparam logic [REGIDX_W-1:0] REG_SLOT_COUNT  = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_TABLE_BASE  = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_SLOT_STRIDE = 2'd2;

	localparam logic [CNT_W-1:0]    SLOT_COUNT_RST  = 11'd1024;
	localparam logic [ADDR_W-1:0]   TABLE_BASE_RST  = 48'd0;
	localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 13'd32;

	typedef struct packed {
		logic start; // request transaction accepted this cycle
		logic load;  // move the finished result into the output register
	} ctrl_cmd_t;

endpackage

// ----- design/dsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free stack.
module dsa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/dsa_datapath.sv -----
// Datapath of the slot allocator: config registers, stack pointer, fresh counter,
// free stack RAM, address multiply and the output payload. Depends on dsa_pkg, dsa_ram.
module dsa_datapath #(
	parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dsa_pkg::ctrl_cmd_t               cmd,
	input  logic [dsa_pkg::MODE_W-1:0]       mode,
	input  logic [dsa_pkg::INDEX_W-1:0]      slot_index,
	input  logic                             cfg_we,
	input  logic [dsa_pkg::REGIDX_W-1:0]     cfg_index,
	input  logic [dsa_pkg::ADDR_W-1:0]       cfg_data,
	output logic [dsa_pkg::INDEX_W-1:0]      granted_index,
	output logic [dsa_pkg::ADDR_W-1:0]       slot_address,
	output logic [dsa_pkg::STAT_W-1:0]       status
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int DW = $clog2(MAX_SLOTS + 1);
	localparam int UW = (dsa_pkg::CNT_W > DW) ? dsa_pkg::CNT_W : DW;

	logic [dsa_pkg::CNT_W-1:0]    slot_count_q;
	logic [dsa_pkg::ADDR_W-1:0]   table_base_q;
	logic [dsa_pkg::STRIDE_W-1:0] slot_stride_q;

	logic [DW-1:0]            depth_q;
	logic [dsa_pkg::CNT_W-1:0] fresh_q;

	logic                         pop_s1;
	logic                         loc_s1;
	logic [dsa_pkg::INDEX_W-1:0]  granted_s1;
	logic [dsa_pkg::STAT_W-1:0]   status_s1;
	logic [dsa_pkg::PROD_W-1:0]   prod_s1;

	logic [dsa_pkg::INDEX_W-1:0]  granted_q;
	logic [dsa_pkg::ADDR_W-1:0]   addr_q;
	logic [dsa_pkg::STAT_W-1:0]   status_q;

	logic [UW-1:0]                usable;
	logic                         stack_empty;
	logic                         stack_full;
	logic                         fresh_out;
	logic                         is_alloc;
	logic                         is_free;
	logic                         is_loc;
	logic                         ram_we;
	logic                         ram_re;
	logic [DW-1:0]                depth_dec;
	logic [dsa_pkg::INDEX_W-1:0]  ram_rdata;

	assign usable = (UW'(slot_count_q) < UW'(MAX_SLOTS)) ? UW'(slot_count_q) : UW'(MAX_SLOTS);
	assign stack_empty = (depth_q == '0);
	assign stack_full  = (depth_q == DW'(MAX_SLOTS));
	assign fresh_out   = (UW'(fresh_q) >= usable);
	assign is_alloc    = (mode == dsa_pkg::MODE_ALLOC);
	assign is_free     = (mode == dsa_pkg::MODE_FREE);
	assign is_loc      = (mode == dsa_pkg::MODE_LOCATE);
	assign depth_dec   = depth_q - 1'b1;
	assign ram_we      = cmd.start && is_free && !stack_full;
	assign ram_re      = cmd.start && is_alloc && !stack_empty;

	dsa_ram #(
		.WIDTH(dsa_pkg::INDEX_W),
		.DEPTH(MAX_SLOTS)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(depth_q[AW-1:0]),
		.wdata(slot_index),
		.re   (ram_re),
		.raddr(depth_dec[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= dsa_pkg::SLOT_COUNT_RST;
			table_base_q  <= dsa_pkg::TABLE_BASE_RST;
			slot_stride_q <= dsa_pkg::SLOT_STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dsa_pkg::REG_SLOT_COUNT:  slot_count_q  <= cfg_data[dsa_pkg::CNT_W-1:0];
				dsa_pkg::REG_TABLE_BASE:  table_base_q  <= cfg_data;
				dsa_pkg::REG_SLOT_STRIDE: slot_stride_q <= cfg_data[dsa_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// stack pointer and fresh counter commit at accept time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fresh_q <= '0;
		end else if (cmd.start) begin
			if (is_alloc) begin
				if (!stack_empty) begin
					depth_q <= depth_dec;
				end else if (!fresh_out) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end else if (is_free && !stack_full) begin
				depth_q <= depth_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pop_s1     <= is_alloc && !stack_empty;
			loc_s1     <= is_loc;
			granted_s1 <= '0;
			status_s1  <= dsa_pkg::STAT_OK;
			prod_s1    <= dsa_pkg::PROD_W'(slot_index) * dsa_pkg::PROD_W'(slot_stride_q);
			if (is_alloc && stack_empty) begin
				if (fresh_out) begin
					status_s1 <= dsa_pkg::STAT_FULL;
				end else begin
					granted_s1 <= fresh_q[dsa_pkg::INDEX_W-1:0];
				end
			end
			if (is_free && stack_full) begin
				status_s1 <= dsa_pkg::STAT_REFUSED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			granted_q <= pop_s1 ? ram_rdata : granted_s1;
			addr_q    <= loc_s1 ? table_base_q + dsa_pkg::ADDR_W'(prod_s1) : '0;
			status_q  <= status_s1;
		end
	end

	assign granted_index = granted_q;
	assign slot_address  = addr_q;
	assign status        = status_q;

endmodule

// ----- design/dsa_ctrl.sv -----
// Controller of the slot allocator: request sequencing and output valid.
// Depends on dsa_pkg.
module dsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output dsa_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic load;
	logic start;

	assign s_tready = (state_q == ST_IDLE);
	assign start    = s_tvalid && s_tready;
	// finish only when the output register is free or drains this cycle
	assign load     = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: if (load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid  = out_valid_q;
	assign cmd.start = start;
	assign cmd.load  = load;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("finished result not presented");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !m_tready) |=> (state_q == ST_EXEC))
		else $error("result finished into an occupied output register");

endmodule

// ----- design/descriptor_slot_allocator.sv -----
// Descriptor slot allocator: top level joining controller and datapath.
// Depends on dsa_pkg, dsa_ctrl, dsa_datapath (and dsa_ram below it).
//
// Usage: requests arrive on the s_ stream (tuser = mode, tdata = slot index).
// Allocate pops the last freed index from a LIFO stack, else grants the next
// never-used index, else reports full. Free pushes an index; a push onto a
// full stack is refused. Locate returns table_base + index * slot_stride.
// Each request yields one result on the m_ stream (tdata = index and address,
// tuser = status).
// Timing: a request is accepted into the execute stage, then its result enters
// the output register; no new request is taken until it has. The execute stage
// holds the registered read of the free stack RAM (and the registered stride
// product for locate). The output register lets the next request be accepted
// while the previous result waits.
// Stall: with m_tready low one more request is accepted and held finished in
// its stage; s_tready then stays low until the output register drains.
// Reset: stack empty, fresh counter at zero, registers at their defaults;
// stack RAM contents are not cleared and need no clearing pass.
// Config writes (cfg_we/cfg_index/cfg_data) are taken in any cycle; the user
// must make them only while no request is outstanding, as the block does not check.
module descriptor_slot_allocator #(
	parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] slot_index, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [9:0] granted_index, [57:10] slot_address, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	dsa_pkg::ctrl_cmd_t                cmd;
	logic [dsa_pkg::INDEX_W-1:0]       granted_index;
	logic [dsa_pkg::ADDR_W-1:0]        slot_address;
	logic [dsa_pkg::STAT_W-1:0]        status;

	dsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	dsa_datapath #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (s_tuser),
		.slot_index   (s_tdata[dsa_pkg::INDEX_W-1:0]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.granted_index(granted_index),
		.slot_address (slot_address),
		.status       (status)
	);

	assign m_tdata = {6'd0, slot_address, granted_index};
	assign m_tuser = status;

endmodule

// ----- tb/sv/tb_descriptor_slot_allocator.sv -----
// Self-checking testbench for descriptor_slot_allocator: a directed table, then
// random allocate/free/locate traffic, checked against a predictor kept here.
// Depends on dsa_pkg and the descriptor_slot_allocator RTL.
module tb_descriptor_slot_allocator;

	localparam int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF;
	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam logic [dsa_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;
	localparam logic [dsa_pkg::ADDR_W-1:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
	// Random idling and config pauses give short gaps only.
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 800;

	typedef struct packed {
		logic [dsa_pkg::INDEX_W-1:0] granted;
		logic [dsa_pkg::ADDR_W-1:0]  address;
		logic [dsa_pkg::STAT_W-1:0]  status;
	} slot_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [1:0]                 sel;    // mode for a request, register index for a write
		logic [dsa_pkg::ADDR_W-1:0] val;    // slot index for a request, data for a write
		bit                         typed;
		slot_result_t               want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	// allocator mirror
	logic [dsa_pkg::INDEX_W-1:0]  freed_slots [MAX_SLOTS];
	int unsigned                  depth_mirror = 0;
	int unsigned                  fresh_mirror = 0;
	logic [dsa_pkg::CNT_W-1:0]    count_mirror = dsa_pkg::SLOT_COUNT_RST;
	logic [dsa_pkg::ADDR_W-1:0]   base_mirror = dsa_pkg::TABLE_BASE_RST;
	logic [dsa_pkg::STRIDE_W-1:0] stride_mirror = dsa_pkg::SLOT_STRIDE_RST;

	slot_result_t owed_results [$];
	stim_row_t    plan [$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           snd_pct = 28;
	int           rcv_pct = 61;

	descriptor_slot_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Pop the last freed slot, else take a fresh one, else report full; push on
	// free unless the stack is full; locate is base + index * stride mod 2^48.
	function automatic slot_result_t next_slot_result(input logic [1:0] kind,
			input logic [dsa_pkg::INDEX_W-1:0] idx);
		slot_result_t r;
		int unsigned  usable;
		r = '0;
		usable = ({21'd0, count_mirror} < MAX_SLOTS) ? {21'd0, count_mirror} : MAX_SLOTS;
		case (kind)
			dsa_pkg::MODE_ALLOC: begin
				if (depth_mirror > 0) begin
					depth_mirror--;
					r.granted = freed_slots[SLOT_AW'(depth_mirror)];
				end else if (fresh_mirror >= usable) begin
					r.status = dsa_pkg::STAT_FULL;
				end else begin
					r.granted = fresh_mirror[dsa_pkg::INDEX_W-1:0];
					fresh_mirror++;
				end
			end
			dsa_pkg::MODE_FREE: begin
				if (depth_mirror >= MAX_SLOTS) begin
					r.status = dsa_pkg::STAT_REFUSED;
				end else begin
					freed_slots[SLOT_AW'(depth_mirror)] = idx;
					depth_mirror++;
				end
			end
			dsa_pkg::MODE_LOCATE: begin
				r.address = base_mirror + {38'd0, idx} * {35'd0, stride_mirror};
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [1:0] sel,
			input logic [dsa_pkg::ADDR_W-1:0] val, input bit typed,
			input logic [dsa_pkg::INDEX_W-1:0] gi,
			input logic [dsa_pkg::ADDR_W-1:0] addr, input logic [dsa_pkg::STAT_W-1:0] st);
		stim_row_t row;
		row.kind = kind;
		row.sel = sel;
		row.val = val;
		row.typed = typed;
		row.want.granted = gi;
		row.want.address = addr;
		row.want.status = st;
		plan.insert(plan.size(), row);
	endtask

	task automatic issue(input logic [1:0] kind, input logic [dsa_pkg::INDEX_W-1:0] idx,
			input bit typed, input slot_result_t typed_res, output slot_result_t res);
		while ($urandom_range(99) < snd_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, idx};
		do @(posedge clk); while (!s_tready);
		res = next_slot_result(kind, idx);
		if (typed)
			res = typed_res;
		owed_results.insert(owed_results.size(), res);
	endtask

	// Hold requests off until every result is back, then let the pipe settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dsa_pkg::REGIDX_W-1:0] idx,
			input logic [47:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dsa_pkg::REG_SLOT_COUNT:  count_mirror = data[dsa_pkg::CNT_W-1:0];
			dsa_pkg::REG_TABLE_BASE:  base_mirror = data[dsa_pkg::ADDR_W-1:0];
			dsa_pkg::REG_SLOT_STRIDE: stride_mirror = data[dsa_pkg::STRIDE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_pct);
	end

	always @(posedge clk) begin
		slot_result_t want;
		slot_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.granted = m_tdata[9:0];
			got.address = m_tdata[57:10];
			got.status = m_tuser;
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing owed: index %0d address %h status %0d",
					$time, got.granted, got.address, got.status);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				if (got.granted !== want.granted) begin
					$display("%0t: granted_index expected %0d actual %0d",
						$time, want.granted, got.granted);
					mismatches++;
				end
				if (got.address !== want.address) begin
					$display("%0t: slot_address expected %h actual %h",
						$time, want.address, got.address);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("descriptor_slot_allocator regression: fail");
			$finish;
		end
	end

	initial begin
		slot_result_t                 res;
		slot_result_t                 none;
		int                           sent;
		int                           batch;
		int                           alloc_pct;
		int                           pick;
		int                           mask;
		int                           pos;
		bit                           filled;
		logic [1:0]                   kind;
		logic [dsa_pkg::INDEX_W-1:0]  idx;
		logic [dsa_pkg::CNT_W-1:0]    count_val;
		logic [dsa_pkg::ADDR_W-1:0]   base_val;
		logic [dsa_pkg::STRIDE_W-1:0] stride_val;
		logic [dsa_pkg::INDEX_W-1:0]  held [$];

		none = '0;
		sent = 0;
		filled = 1'b0;

		// fresh grants, locate extremes, LIFO order, reserved mode
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 1023, 1, 10'd1, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_LOCATE, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_LOCATE, 1023, 1, 10'd0, 48'd32736, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_FREE, 1023, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd1023, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_FREE, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_FREE, 682, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd682, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, MODE_RESERVED, 1023, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		// count lowered near the fresh pointer, then to zero
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_COUNT, 3, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd2, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_FULL);
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_COUNT, 0, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_FREE, 341, 1, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd341, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_ALLOC, 0, 1, 10'd0, 48'd0, dsa_pkg::STAT_FULL);
		// address wrap, zero stride, oversized count
		add_row(ROW_CFG, dsa_pkg::REG_TABLE_BASE, ADDR_MAX, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_STRIDE, 8191, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_LOCATE, 1023, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_STRIDE, 0, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_LOCATE, 555, 1, 10'd0, ADDR_MAX, dsa_pkg::STAT_OK);
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_COUNT, 2047, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_CFG, dsa_pkg::REG_SLOT_STRIDE, 1, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_CFG, dsa_pkg::REG_TABLE_BASE, 0, 0, 10'd0, 48'd0, dsa_pkg::STAT_OK);
		add_row(ROW_REQ, dsa_pkg::MODE_LOCATE, 1023, 1, 10'd0, 48'd1023, dsa_pkg::STAT_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				issue(plan[i].sel, plan[i].val[dsa_pkg::INDEX_W-1:0], plan[i].typed,
					plan[i].want, res);
			end
		end

		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				snd_pct = 28;
				rcv_pct = 61;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				snd_pct = 61;
				rcv_pct = 28;
			end else begin
				snd_pct = 0;
				rcv_pct = 0;
			end

			// fill the stack to the brim, overflow it, then pop some back
			if (!filled && sent >= RANDOM_ITEMS / 2) begin
				filled = 1'b1;
				while (depth_mirror < MAX_SLOTS)
					issue(dsa_pkg::MODE_FREE, 10'($urandom_range(1023)), 0, none, res);
				repeat (3) issue(dsa_pkg::MODE_FREE, 10'($urandom_range(1023)), 0, none, res);
				repeat (30) begin
					issue(dsa_pkg::MODE_ALLOC, 10'($urandom_range(1023)), 0, none, res);
					if (res.status == dsa_pkg::STAT_OK)
						held.insert(held.size(), res.granted);
				end
			end

			drain();
			mask = $urandom_range(1, 7);
			if (mask[0]) begin
				pick = $urandom_range(9);
				case (pick)
					0: count_val = 11'd0;
					1: count_val = 11'd1;
					2: count_val = 11'd1024;
					3: count_val = 11'd2047;
					4: count_val = fresh_mirror[dsa_pkg::CNT_W-1:0];
					5: count_val = fresh_mirror[dsa_pkg::CNT_W-1:0] + 11'($urandom_range(1, 8));
					default: count_val = 11'($urandom_range(1, 1024));
				endcase
				write_reg(dsa_pkg::REG_SLOT_COUNT, {37'd0, count_val});
			end
			if (mask[1]) begin
				pick = $urandom_range(3);
				base_val = (pick == 0) ? '0 : (pick == 1) ? ADDR_MAX :
					{16'($urandom_range(16'hFFFF)), 32'($urandom())};
				write_reg(dsa_pkg::REG_TABLE_BASE, base_val);
			end
			if (mask[2]) begin
				pick = $urandom_range(7);
				case (pick)
					0: stride_val = 13'd0;
					1: stride_val = 13'd1;
					2: stride_val = 13'd4096;
					3: stride_val = 13'd8191;
					default: stride_val = 13'($urandom_range(1, 4096));
				endcase
				write_reg(dsa_pkg::REG_SLOT_STRIDE, {35'd0, stride_val});
			end

			batch = $urandom_range(20, 80);
			alloc_pct = $urandom_range(25, 65);
			repeat (batch) begin
				pick = $urandom_range(99);
				idx = 10'($urandom_range(1023));
				if (pick < alloc_pct) begin
					kind = dsa_pkg::MODE_ALLOC;
				end else if (pick < alloc_pct + 30) begin
					kind = dsa_pkg::MODE_FREE;
					// mostly give back a slot we hold; otherwise a stray or double free
					if (held.size() != 0 && $urandom_range(9) < 8) begin
						pos = $urandom_range(held.size() - 1);
						idx = held[pos];
						held.delete(pos);
					end
				end else if (pick < 97) begin
					kind = dsa_pkg::MODE_LOCATE;
					if ($urandom_range(9) == 0)
						idx = $urandom_range(1) ? 10'd1023 : 10'd0;
				end else begin
					kind = MODE_RESERVED;
				end
				issue(kind, idx, 0, none, res);
				if (kind == dsa_pkg::MODE_ALLOC && res.status == dsa_pkg::STAT_OK)
					held.insert(held.size(), res.granted);
				sent++;
			end
		end

		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("descriptor_slot_allocator regression: pass");
		else
			$display("descriptor_slot_allocator regression: fail");
		$finish;
	end

endmodule
